// File: hdl/ppu_pkg.sv
// Shared types, constants and phase logic of the packed pattern unpacker.
package ppu_pkg;

    localparam int CHANNELS   = 64;
    localparam int MAX_ROWS   = 256;
    localparam int CHAN_SLOTS = 64;
    localparam int CHAN_W     = 6;
    localparam int ROW_W      = 9;

    localparam logic [ROW_W-1:0] ROWS_RESET = 9'd64;

    // register index of pattern_rows (paddr[2])
    localparam logic REG_PATTERN_ROWS = 1'b0;

    typedef enum logic [6:0] {
        PH_CHAN = 7'b0000001,
        PH_MASK = 7'b0000010,
        PH_NOTE = 7'b0000100,
        PH_INST = 7'b0001000,
        PH_VOL  = 7'b0010000,
        PH_CMD  = 7'b0100000,
        PH_OPER = 7'b1000000
    } phase_t;

    // per-channel memory record
    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] volume;
        logic [7:0] command;
        logic [7:0] operand;
    } rec_t;

    typedef struct packed {
        logic              en;
        logic [CHAN_W-1:0] addr;
        rec_t              data;
    } mem_wr_t;

    typedef struct packed {
        logic [7:0]        row;
        logic [CHAN_W-1:0] channel;
        logic              note_valid;
        logic [7:0]        note;
        logic              instrument_valid;
        logic [7:0]        instrument;
        logic              volume_valid;
        logic [7:0]        volume;
        logic              command_valid;
        logic [7:0]        command;
        logic [7:0]        operand;
    } cell_t;

    // next fetch phase after p under mask m; PH_CHAN means the entry is done
    function automatic phase_t next_phase(input phase_t p, input logic [7:0] m);
        phase_t q;
        q = PH_CHAN;
        case (p)
            PH_MASK:
            begin
                if (m[0])
                    q = PH_NOTE;
                else if (m[1])
                    q = PH_INST;
                else if (m[2])
                    q = PH_VOL;
                else if (m[3])
                    q = PH_CMD;
            end
            PH_NOTE:
            begin
                if (m[1])
                    q = PH_INST;
                else if (m[2])
                    q = PH_VOL;
                else if (m[3])
                    q = PH_CMD;
            end
            PH_INST:
            begin
                if (m[2])
                    q = PH_VOL;
                else if (m[3])
                    q = PH_CMD;
            end
            PH_VOL:
            begin
                if (m[3])
                    q = PH_CMD;
            end
            PH_CMD:
                q = PH_OPER;
            default:
                q = PH_CHAN;
        endcase
        return q;
    endfunction

endpackage

// File: hdl/ppu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ppu_parser.sv
// Byte parser: phase tracking, channel record, seen bits and row counter.
module ppu_parser import ppu_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             proc,
    input  logic             first_byte,
    input  logic [7:0]       packed_byte,
    input  logic [ROW_W-1:0] pattern_rows,
    input  rec_t             mem_rec,
    output logic             emit,
    output cell_t            cell_out,
    output mem_wr_t          mem_wr
);

    phase_t               phase_reg, phase_next, phase_cur;
    logic [CHAN_W-1:0]    chan_reg, chan_next;
    rec_t                 rec_reg, rec_next, rec_base;
    logic [ROW_W-1:0]     row_reg, row_next, row_cur, rows_eff;
    logic [CHAN_SLOTS-1:0] seen_reg, seen_next, seen_cur;
    logic                 wr_en;
    logic                 done;

    always_comb
    begin
        phase_cur  = first_byte ? PH_CHAN : phase_reg;
        seen_cur   = first_byte ? '0 : seen_reg;
        row_cur    = first_byte ? '0 : row_reg;
        phase_next = phase_cur;
        seen_next  = seen_cur;
        row_next   = row_cur;
        chan_next  = chan_reg;
        rec_next   = rec_reg;
        rec_base   = '0;
        wr_en      = 1'b0;
        done       = 1'b0;
        case (phase_cur)
            PH_CHAN:
            begin
                if (packed_byte == 8'd0)
                begin
                    if (row_cur < ROW_W'(MAX_ROWS))
                        row_next = row_cur + 1'b1;
                end
                else
                begin
                    chan_next = packed_byte[CHAN_W-1:0] - 1'b1;
                    rec_base  = seen_cur[chan_next] ? mem_rec : '0;
                    seen_next[chan_next] = 1'b1;
                    rec_next  = rec_base;
                    wr_en     = 1'b1;
                    if (packed_byte[7])
                        phase_next = PH_MASK;
                    else
                    begin
                        phase_next = next_phase(PH_MASK, rec_base.mask);
                        done       = (phase_next == PH_CHAN);
                    end
                end
            end
            PH_MASK:
            begin
                rec_next.mask = packed_byte;
                wr_en         = 1'b1;
                phase_next    = next_phase(PH_MASK, packed_byte);
                done          = (phase_next == PH_CHAN);
            end
            PH_NOTE:
            begin
                rec_next.note = packed_byte;
                wr_en         = 1'b1;
                phase_next    = next_phase(PH_NOTE, rec_reg.mask);
                done          = (phase_next == PH_CHAN);
            end
            PH_INST:
            begin
                rec_next.instrument = packed_byte;
                wr_en               = 1'b1;
                phase_next          = next_phase(PH_INST, rec_reg.mask);
                done                = (phase_next == PH_CHAN);
            end
            PH_VOL:
            begin
                rec_next.volume = packed_byte;
                wr_en           = 1'b1;
                phase_next      = next_phase(PH_VOL, rec_reg.mask);
                done            = (phase_next == PH_CHAN);
            end
            PH_CMD:
            begin
                rec_next.command = packed_byte;
                wr_en            = 1'b1;
                phase_next       = next_phase(PH_CMD, rec_reg.mask);
                done             = (phase_next == PH_CHAN);
            end
            PH_OPER:
            begin
                rec_next.operand = packed_byte;
                wr_en            = 1'b1;
                phase_next       = PH_CHAN;
                done             = 1'b1;
            end
            default:
                phase_next = PH_CHAN;
        endcase
    end

    assign rows_eff = (pattern_rows > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : pattern_rows;

    assign emit = proc && done && (row_cur < rows_eff)
                  && ({1'b0, chan_next} < (CHAN_W + 1)'(CHANNELS));

    always_comb
    begin
        cell_out.row              = row_cur[7:0];
        cell_out.channel          = chan_next;
        cell_out.note_valid       = rec_next.mask[0] | rec_next.mask[4];
        cell_out.instrument_valid = rec_next.mask[1] | rec_next.mask[5];
        cell_out.volume_valid     = rec_next.mask[2] | rec_next.mask[6];
        cell_out.command_valid    = rec_next.mask[3] | rec_next.mask[7];
        cell_out.note       = cell_out.note_valid ? rec_next.note : 8'd0;
        cell_out.instrument = cell_out.instrument_valid ? rec_next.instrument : 8'd0;
        cell_out.volume     = cell_out.volume_valid ? rec_next.volume : 8'd0;
        cell_out.command    = cell_out.command_valid ? rec_next.command : 8'd0;
        cell_out.operand    = cell_out.command_valid ? rec_next.operand : 8'd0;
    end

    assign mem_wr.en   = proc && wr_en;
    assign mem_wr.addr = chan_next;
    assign mem_wr.data = rec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CHAN;
            chan_reg  <= '0;
            rec_reg   <= '0;
            row_reg   <= '0;
            seen_reg  <= '0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            rec_reg   <= rec_next;
            row_reg   <= row_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// File: hdl/packed_pattern_unpacker.sv
// Top level of the packed pattern unpacker: handshakes, register port, record memory.
//
// Takes one packed pattern byte per cycle while out_stall is low, with no gaps
// of its own: a byte sits in the input register while its channel record comes
// out of the 64-entry record memory (read at request time, bypassed against the
// write of the byte before), then the parser finishes it in one pass into the
// result register. Channel records are validated by per-channel seen bits, so
// reset and first_byte need no clearing pass. The user must write pattern_rows
// only while the block is idle; the block itself does not enforce this.
module packed_pattern_unpacker import ppu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        first_byte,
    input  logic [7:0]  packed_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  row,
    output logic [5:0]  channel,
    output logic        note_valid,
    output logic [7:0]  note,
    output logic        instrument_valid,
    output logic [7:0]  instrument,
    output logic        volume_valid,
    output logic [7:0]  volume,
    output logic        command_valid,
    output logic [7:0]  command,
    output logic [7:0]  operand
);

    logic [ROW_W-1:0]     rows_reg;
    logic                 in_v_reg;
    logic                 first_reg;
    logic [7:0]           byte_reg;
    logic                 out_v_reg;
    cell_t                cell_reg;
    logic                 byp_v_reg;
    rec_t                 byp_d_reg;
    logic                 adv;
    logic                 proc;
    logic                 accept;
    logic [CHAN_W-1:0]    raddr;
    logic [$bits(rec_t)-1:0] rdata;
    rec_t                 mem_rec;
    logic                 emit;
    cell_t                cell_out;
    mem_wr_t              mem_wr;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PATTERN_ROWS) ? {{(32 - ROW_W){1'b0}}, rows_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_reg <= ROWS_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_PATTERN_ROWS))
            rows_reg <= pwdata[ROW_W-1:0];
    end

    // request flow
    assign adv      = !out_v_reg || !out_stall;
    assign in_stall = in_v_reg && !adv;
    assign accept   = in_valid && !in_stall;
    assign proc     = in_v_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (accept)
            in_v_reg <= 1'b1;
        else if (adv)
            in_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg <= first_byte;
            byte_reg  <= packed_byte;
        end
    end

    // record memory; re-read the held byte's slot while stalled
    assign raddr = in_stall ? (byte_reg[CHAN_W-1:0] - 1'b1) : (packed_byte[CHAN_W-1:0] - 1'b1);

    ppu_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (CHAN_SLOTS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_v_reg <= 1'b0;
        else
            byp_v_reg <= mem_wr.en && (mem_wr.addr == raddr);
    end

    always_ff @(posedge clk)
    begin
        byp_d_reg <= mem_wr.data;
    end

    assign mem_rec = byp_v_reg ? byp_d_reg : rec_t'(rdata);

    ppu_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .proc         (proc),
        .first_byte   (first_reg),
        .packed_byte  (byte_reg),
        .pattern_rows (rows_reg),
        .mem_rec      (mem_rec),
        .emit         (emit),
        .cell_out     (cell_out),
        .mem_wr       (mem_wr)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (proc && emit)
            out_v_reg <= 1'b1;
        else if (!out_stall)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
            cell_reg <= cell_out;
    end

    assign out_valid        = out_v_reg;
    assign row              = cell_reg.row;
    assign channel          = cell_reg.channel;
    assign note_valid       = cell_reg.note_valid;
    assign note             = cell_reg.note;
    assign instrument_valid = cell_reg.instrument_valid;
    assign instrument       = cell_reg.instrument;
    assign volume_valid     = cell_reg.volume_valid;
    assign volume           = cell_reg.volume;
    assign command_valid    = cell_reg.command_valid;
    assign command          = cell_reg.command;
    assign operand          = cell_reg.operand;

endmodule
